// File: hw/rtl/vdar_pkg.sv
package vdar_pkg;

  localparam int unsigned AXES  = 3;
  localparam int unsigned FW    = 16;   // field width, signed fixed point
  localparam int unsigned QW    = 16;   // normalised magnitude, one cell per bit
  localparam int unsigned LENW  = 32;   // squared length
  localparam int unsigned LW    = LENW + QW; // q * len
  localparam int unsigned THW   = 15;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER  = 2'd0,
    REG_UPPER  = 2'd1,
    REG_RADIAL = 2'd2
  } cfg_reg_e;

  // per-beat control and early result travelling down the cell row
  typedef struct packed {
    logic                     valid;
    logic                     norm;   // take the normalised magnitude
    logic [AXES-1:0]          neg;
    logic [AXES-1:0][FW-1:0]  res;    // result when norm is clear
  } item_t;

endpackage

// File: hw/rtl/vdar_cell.sv
module vdar_cell #(
  parameter int unsigned FRAC_BITS = 14,
  parameter int unsigned K         = 0,
  parameter int unsigned W         = 65
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            en_i,
  input  vdar_pkg::item_t                                 item_i,
  input  logic [vdar_pkg::LENW-1:0]                       len_i,
  input  logic [vdar_pkg::AXES-1:0][W-1:0]                rem_i,
  input  logic [vdar_pkg::AXES-1:0][vdar_pkg::LW-1:0]     lq_i,
  input  logic [vdar_pkg::AXES-1:0][vdar_pkg::QW-1:0]     q_i,
  output vdar_pkg::item_t                                 item_o,
  output logic [vdar_pkg::LENW-1:0]                       len_o,
  output logic [vdar_pkg::AXES-1:0][W-1:0]                rem_o,
  output logic [vdar_pkg::AXES-1:0][vdar_pkg::LW-1:0]     lq_o,
  output logic [vdar_pkg::AXES-1:0][vdar_pkg::QW-1:0]     q_o
);
  import vdar_pkg::*;

  localparam logic [QW:0] CAP = (FRAC_BITS >= 15) ? (QW+1)'(32768)
                                                  : (QW+1)'(1 << FRAC_BITS);

  logic [AXES-1:0][W-1:0]    rem_d;
  logic [AXES-1:0][LW-1:0]   lq_d;
  logic [AXES-1:0][QW-1:0]   q_d;

  logic                      valid_q;
  logic                      norm_q;
  logic [AXES-1:0]           neg_q;
  logic [AXES-1:0][FW-1:0]   res_q;

  // (q + 2^K)^2 * len = q^2*len + (q*len)<<(K+1) + len<<2K
  always_comb begin
    logic [W-1:0]  cand;
    logic [QW-1:0] qt;
    for (int a = 0; a < AXES; a++) begin
      cand = (W'(lq_i[a]) << (K + 1)) + (W'(len_i) << (2 * K));
      qt   = q_i[a] | (QW'(1) << K);
      if ((cand <= rem_i[a]) && ({1'b0, qt} <= CAP)) begin
        rem_d[a] = rem_i[a] - cand;
        lq_d[a]  = lq_i[a] + (LW'(len_i) << K);
        q_d[a]   = qt;
      end else begin
        rem_d[a] = rem_i[a];
        lq_d[a]  = lq_i[a];
        q_d[a]   = q_i[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q <= item_i.norm;
      neg_q  <= item_i.neg;
      res_q  <= item_i.res;
      len_o  <= len_i;
      rem_o  <= rem_d;
      lq_o   <= lq_d;
      q_o    <= q_d;
    end
  end

  assign item_o = '{valid: valid_q, norm: norm_q, neg: neg_q, res: res_q};

endmodule

// File: hw/rtl/vector_deadzone_axial_radial_top.sv
// Three-axis deadzone on signed fixed-point vectors (FRAC_BITS fraction bits,
// 1.0 = 2^FRAC_BITS). radial_mode = 0: each axis alone, |c| < lower gives 0,
// |c| > upper gives +/-1.0 (saturated to 16 bits), else unchanged.
// radial_mode = 1: x^2+y^2+z^2 against lower^2 / upper^2; below gives the zero
// vector, above gives the vector scaled to unit length (truncated toward zero,
// saturated), equal or between passes unchanged. One beat per clock in and
// out while no output beat waits; beats pass the row of sixteen cells that
// resolve the normalised magnitude one bit each. The whole pipeline holds
// while an output beat waits. A beat accepted at or after the edge of a
// register write sees the new value; beats already in flight may see a mix,
// so write registers only while the pipeline is empty.
module vector_deadzone_axial_radial_top #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config
  input  logic                             cfg_we_i,
  input  logic [vdar_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [vdar_pkg::THW-1:0]         cfg_wdata_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [47:0]                      s_axis_tdata,  // axis_x_in, axis_y_in, axis_z_in
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [47:0]                      m_axis_tdata   // axis_x_out, axis_y_out, axis_z_out
);
  import vdar_pkg::*;

  localparam int unsigned TW = 31 + 2 * FRAC_BITS;
  localparam int unsigned W  = (TW > 65) ? TW : 65;
  localparam logic [FW-1:0] ONE_POS = (FRAC_BITS >= 15) ? 16'h7FFF
                                                        : FW'(1 << FRAC_BITS);
  localparam logic [FW-1:0] ONE_NEG = (FRAC_BITS >= 15) ? 16'h8000
                                      : FW'(32'h10000 - (32'd1 << FRAC_BITS));

  // configuration registers and squared thresholds
  logic [THW-1:0]     lower_q, upper_q;
  logic               radial_q;
  logic [2*THW-1:0]   lsq_q, usq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q  <= THW'(3277);
      upper_q  <= THW'(13107);
      radial_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LOWER:  lower_q  <= cfg_wdata_i;
        REG_UPPER:  upper_q  <= cfg_wdata_i;
        REG_RADIAL: radial_q <= cfg_wdata_i[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    lsq_q <= lower_q * lower_q;
    usq_q <= upper_q * upper_q;
  end

  // global advance: everything moves unless the output beat is stuck
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: capture
  logic                     s1_valid_q;
  logic [AXES-1:0][FW-1:0]  s1_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x_q <= s_axis_tdata;
    end
  end

  // stage 2: squares, magnitudes, axial result
  logic                      s2_valid_q;
  logic [AXES-1:0][FW-1:0]   s2_x_q, s2_ax_q, s2_ax_d;
  logic [AXES-1:0][LENW-1:0] s2_sq_q, s2_sq_d;
  logic [AXES-1:0]           s2_neg_q;

  always_comb begin
    logic [FW:0] mag;
    for (int a = 0; a < AXES; a++) begin
      mag        = s1_x_q[a][FW-1] ? (FW+1)'(0) - {1'b1, s1_x_q[a]}
                                   : {1'b0, s1_x_q[a]};
      s2_sq_d[a] = LENW'($signed(s1_x_q[a]) * $signed(s1_x_q[a]));
      if (mag < (FW+1)'(lower_q)) begin
        s2_ax_d[a] = '0;
      end else if (mag > (FW+1)'(upper_q)) begin
        s2_ax_d[a] = s1_x_q[a][FW-1] ? ONE_NEG : ONE_POS;
      end else begin
        s2_ax_d[a] = s1_x_q[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_x_q  <= s1_x_q;
      s2_ax_q <= s2_ax_d;
      s2_sq_q <= s2_sq_d;
      for (int a = 0; a < AXES; a++) s2_neg_q[a] <= s1_x_q[a][FW-1];
    end
  end

  // stage 3 (combinational feed of the row): length and decision
  logic [LENW-1:0] len;
  logic            below, above;
  item_t           head;
  logic [AXES-1:0][W-1:0] rem0;

  assign len   = s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
  assign below = len < LENW'(lsq_q);
  assign above = len > LENW'(usq_q);

  always_comb begin
    head.valid = s2_valid_q;
    head.neg   = s2_neg_q;
    head.norm  = radial_q && !below && above;
    for (int a = 0; a < AXES; a++) begin
      if (!radial_q)  head.res[a] = s2_ax_q[a];
      else if (below) head.res[a] = '0;
      else            head.res[a] = s2_x_q[a];
      // mag^2 * 2^(2F): the budget the candidate's q^2*len must fit in
      rem0[a] = W'(s2_sq_q[a]) << (2 * FRAC_BITS);
    end
  end

  // cell row, MSB first
  item_t                        c_item [QW+1];
  logic [LENW-1:0]              c_len  [QW+1];
  logic [AXES-1:0][W-1:0]       c_rem  [QW+1];
  logic [AXES-1:0][LW-1:0]      c_lq   [QW+1];
  logic [AXES-1:0][QW-1:0]      c_q    [QW+1];

  assign c_item[0] = head;
  assign c_len[0]  = len;
  assign c_rem[0]  = rem0;
  assign c_lq[0]   = '0;
  assign c_q[0]    = '0;

  for (genvar g = 0; g < QW; g++) begin : g_cell
    vdar_cell #(
      .FRAC_BITS (FRAC_BITS),
      .K         (QW - 1 - g),
      .W         (W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .item_i (c_item[g]),
      .len_i  (c_len[g]),
      .rem_i  (c_rem[g]),
      .lq_i   (c_lq[g]),
      .q_i    (c_q[g]),
      .item_o (c_item[g+1]),
      .len_o  (c_len[g+1]),
      .rem_o  (c_rem[g+1]),
      .lq_o   (c_lq[g+1]),
      .q_o    (c_q[g+1])
    );
  end

  // output register: pass the early result, or sign and saturate the normalised magnitude
  item_t                    tail;
  logic [AXES-1:0][FW-1:0]  out_d;

  assign tail = c_item[QW];

  always_comb begin
    logic [QW-1:0] q;
    for (int a = 0; a < AXES; a++) begin
      q = c_q[QW][a];
      if (!tail.norm)      out_d[a] = tail.res[a];
      else if (tail.neg[a]) out_d[a] = FW'((QW+1)'(0) - {1'b0, q});
      else if (q[QW-1])    out_d[a] = 16'h7FFF;
      else                 out_d[a] = q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= tail.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= out_d;
    end
  end

  // checks
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> s1_valid_q)
    else $error("accepted beat did not enter the pipeline");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(s1_valid_q) && $stable(s2_valid_q)))
    else $error("pipeline moved during a stall");

  a_q_capped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> ((c_q[QW][0] <= 16'h8000) && (c_q[QW][1] <= 16'h8000)
                    && (c_q[QW][2] <= 16'h8000)))
    else $error("normalised magnitude above unit cap");

endmodule
